// ===== sv/lc3x_pkg.sv =====
// lc3x_pkg: shared types, constants and decode helpers for the lc-3 executor
// no dependencies
package lc3x_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [15:0] START_RESET = 16'h3000;
  localparam logic [2:0]  FLAGS_RESET = 3'b010;

  // request codes
  localparam logic [2:0] REQ_EXEC    = 3'd0;
  localparam logic [2:0] REQ_MEM_WR  = 3'd1;
  localparam logic [2:0] REQ_MEM_RD  = 3'd2;
  localparam logic [2:0] REQ_REG_RD  = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;
  localparam logic [1:0] ST_TRAP     = 2'd3;

  // opcodes
  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_RES  = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [3:0] RIDX_PC    = 4'd8;
  localparam logic [3:0] RIDX_FLAGS = 4'd9;

  // memory address source
  typedef enum logic [1:0] {
    MA_REQ  = 2'd0,
    MA_EA   = 2'd1,
    MA_RDAT = 2'd2
  } maddr_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_req;   // capture accepted item
    logic       exec;       // run first part of execute
    logic       mem_rd;     // issue memory read
    logic       mem_wr;     // issue memory write
    maddr_sel_t addr_sel;
    logic       wb_mem;     // write rdata to dr with flags
    logic       rti_fin;    // pc from rdata, r6 += 1
    logic       finish;     // load output register
  } lc3x_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] opcode;
    logic       halted;
  } lc3x_sts_t;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'd0)  return 3'b010;
    else if (v[15])  return 3'b100;
    else             return 3'b001;
  endfunction

  function automatic logic [15:0] sext9(input logic [15:0] i);
    return {{7{i[8]}}, i[8:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] i);
    return {{10{i[5]}}, i[5:0]};
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] i);
    return {{11{i[4]}}, i[4:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] i);
    return {{5{i[10]}}, i[10:0]};
  endfunction

endpackage

// ===== sv/lc3x_if.sv =====
// lc3x_req_if / lc3x_rsp_if: valid-ready channels for request and result items
// depends on nothing
interface lc3x_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] instruction;
  logic [15:0] mem_address;
  logic [15:0] write_data;
  logic [3:0]  reg_index;
  modport source (output valid, req_type, instruction, mem_address, write_data, reg_index,
                  input ready);
  modport sink   (input valid, req_type, instruction, mem_address, write_data, reg_index,
                  output ready);
endinterface

interface lc3x_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] read_data;
  logic [15:0] next_pc;
  logic [2:0]  cond_flags;
  logic [7:0]  trap_vector;
  modport source (output valid, status, read_data, next_pc, cond_flags, trap_vector,
                  input ready);
  modport sink   (input valid, status, read_data, next_pc, cond_flags, trap_vector,
                  output ready);
endinterface

// ===== sv/lc3x_datapath.sv =====
// lc3x_datapath: register file, pc, flags, word memory and result register
// depends on lc3x_pkg
module lc3x_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lc3x_pkg::lc3x_cmd_t     cmd,
  output lc3x_pkg::lc3x_sts_t     sts,
  input  logic [2:0]              in_req_type,
  input  logic [15:0]             in_instruction,
  input  logic [15:0]             in_mem_address,
  input  logic [15:0]             in_write_data,
  input  logic [3:0]              in_reg_index,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata,
  output logic [1:0]              res_status,
  output logic [15:0]             res_read_data,
  output logic [15:0]             res_next_pc,
  output logic [2:0]              res_cond_flags,
  output logic [7:0]              res_trap_vector
);

  logic [15:0] gpr_r [8];
  logic [15:0] pc_r, start_r;
  logic [2:0]  cc_r;
  logic        halted_r;
  logic [2:0]  req_r;
  logic [15:0] ins_r, addr_r, wdat_r, ea_r;
  logic [3:0]  ridx_r;
  logic [1:0]  st_r;
  logic [7:0]  vec_r;
  logic [15:0] mem [lc3x_pkg::MEM_WORDS];
  logic [15:0] rdata_r;

  logic [2:0]  dr, sr1, sr2;
  logic [15:0] pc_inc, src1, src2, off9;
  logic [15:0] maddr, wdata, rd_val;

  assign dr     = ins_r[11:9];
  assign sr1    = ins_r[8:6];
  assign sr2    = ins_r[2:0];
  assign pc_inc = pc_r + 16'd1;
  assign src1   = gpr_r[sr1];
  assign src2   = ins_r[5] ? lc3x_pkg::sext5(ins_r) : gpr_r[sr2];
  assign off9   = lc3x_pkg::sext9(ins_r);

  assign sts.req_type = req_r;
  assign sts.opcode   = ins_r[15:12];
  assign sts.halted   = halted_r;

  // memory address and write data selection
  always_comb begin
    case (cmd.addr_sel)
      lc3x_pkg::MA_REQ:  maddr = addr_r;
      lc3x_pkg::MA_EA:   maddr = ea_r;
      lc3x_pkg::MA_RDAT: maddr = rdata_r;
      default:           maddr = addr_r;
    endcase
    wdata = (req_r == lc3x_pkg::REQ_MEM_WR) ? wdat_r : gpr_r[dr];
  end

  // single-port word memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[maddr[lc3x_pkg::MEM_AW-1:0]] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[maddr[lc3x_pkg::MEM_AW-1:0]];
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= in_req_type;
      ins_r  <= in_instruction;
      addr_r <= in_mem_address;
      wdat_r <= in_write_data;
      ridx_r <= in_reg_index;
    end
  end

  // register read mux
  always_comb begin
    if (ridx_r[3] == 1'b0)                 rd_val = gpr_r[ridx_r[2:0]];
    else if (ridx_r == lc3x_pkg::RIDX_PC)    rd_val = pc_r;
    else if (ridx_r == lc3x_pkg::RIDX_FLAGS) rd_val = {13'd0, cc_r};
    else                                   rd_val = 16'd0;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) gpr_r[i] <= 16'd0;
      pc_r     <= lc3x_pkg::START_RESET;
      start_r  <= lc3x_pkg::START_RESET;
      cc_r     <= lc3x_pkg::FLAGS_RESET;
      halted_r <= 1'b0;
      st_r     <= lc3x_pkg::ST_OK;
      vec_r    <= 8'd0;
    end else begin
      if (cfg_we) start_r <= cfg_wdata;
      if (cmd.load_req) begin
        st_r  <= lc3x_pkg::ST_OK;
        vec_r <= 8'd0;
        if (in_req_type == lc3x_pkg::REQ_RESTART) begin
          pc_r     <= start_r;
          halted_r <= 1'b0;
        end
        if (in_req_type == lc3x_pkg::REQ_EXEC && halted_r) st_r <= lc3x_pkg::ST_IGNORED;
      end
      // execute step: pc increment, register-only ops, effective address, halt and trap
      if (cmd.exec) begin
        pc_r <= pc_inc;
        ea_r <= pc_inc + off9;
        case (ins_r[15:12])
          lc3x_pkg::OP_BR:
            if ((dr & cc_r) != 3'd0) pc_r <= pc_inc + off9;
          lc3x_pkg::OP_ADD: begin
            gpr_r[dr] <= src1 + src2;
            cc_r      <= lc3x_pkg::nzp(src1 + src2);
          end
          lc3x_pkg::OP_AND: begin
            gpr_r[dr] <= src1 & src2;
            cc_r      <= lc3x_pkg::nzp(src1 & src2);
          end
          lc3x_pkg::OP_NOT: begin
            gpr_r[dr] <= ~src1;
            cc_r      <= lc3x_pkg::nzp(~src1);
          end
          lc3x_pkg::OP_LEA: begin
            gpr_r[dr] <= pc_inc + off9;
            cc_r      <= lc3x_pkg::nzp(pc_inc + off9);
          end
          lc3x_pkg::OP_JSR: begin
            gpr_r[7] <= pc_inc;
            pc_r     <= ins_r[11] ? pc_inc + lc3x_pkg::sext11(ins_r) : src1;
          end
          lc3x_pkg::OP_JMP: pc_r <= src1;
          lc3x_pkg::OP_LDR, lc3x_pkg::OP_STR: ea_r <= src1 + lc3x_pkg::sext6(ins_r);
          lc3x_pkg::OP_RTI: ea_r <= gpr_r[6];
          lc3x_pkg::OP_RES: begin
            halted_r <= 1'b1;
            st_r     <= lc3x_pkg::ST_RESERVED;
          end
          lc3x_pkg::OP_TRAP: begin
            gpr_r[7] <= pc_inc;
            st_r     <= lc3x_pkg::ST_TRAP;
            vec_r    <= ins_r[7:0];
          end
          default: ;
        endcase
      end
      if (cmd.wb_mem) begin
        gpr_r[dr] <= rdata_r;
        cc_r      <= lc3x_pkg::nzp(rdata_r);
      end
      if (cmd.rti_fin) begin
        pc_r     <= rdata_r;
        gpr_r[6] <= gpr_r[6] + 16'd1;
      end
    end
  end

  // result fields, sampled on finish
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status      <= st_r;
      res_next_pc     <= pc_r;
      res_cond_flags  <= cc_r;
      res_trap_vector <= vec_r;
      case (req_r)
        lc3x_pkg::REQ_MEM_RD: res_read_data <= rdata_r;
        lc3x_pkg::REQ_REG_RD: res_read_data <= rd_val;
        default:              res_read_data <= 16'd0;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_rdwr: assert property (@(posedge clk) disable iff (!rst_n) !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in one cycle");
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.exec && ins_r[15:12] == lc3x_pkg::OP_RES |=> halted_r)
    else $error("reserved opcode did not halt");
  a_no_exec_halted: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.exec |-> !halted_r)
    else $error("execute while halted");
`endif

endmodule

// ===== sv/lc3x_ctrl.sv =====
// lc3x_ctrl: sequencer issuing datapath commands and the channel handshakes
// depends on lc3x_pkg
module lc3x_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  lc3x_pkg::lc3x_sts_t sts,
  output lc3x_pkg::lc3x_cmd_t cmd,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MEM1  = 6'b001000,
    S_WB    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   op_ld, op_ind, op_st, op_rti;

  assign op_ld  = sts.opcode == lc3x_pkg::OP_LD || sts.opcode == lc3x_pkg::OP_LDR;
  assign op_ind = sts.opcode == lc3x_pkg::OP_LDI || sts.opcode == lc3x_pkg::OP_STI;
  assign op_st  = sts.opcode == lc3x_pkg::OP_ST || sts.opcode == lc3x_pkg::OP_STR;
  assign op_rti = sts.opcode == lc3x_pkg::OP_RTI;

  // accept when idle; the result register is free once fin can load it
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.addr_sel  = lc3x_pkg::MA_REQ;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load_req = 1'b1;
        state_nxt    = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_FIN;
        case (sts.req_type)
          lc3x_pkg::REQ_EXEC: if (!sts.halted) begin
            cmd.exec  = 1'b1;
            state_nxt = S_EXEC;
          end
          lc3x_pkg::REQ_MEM_WR: cmd.mem_wr = 1'b1;
          lc3x_pkg::REQ_MEM_RD: cmd.mem_rd = 1'b1;
          default: ;
        endcase
      end
      S_EXEC: begin
        cmd.addr_sel = lc3x_pkg::MA_EA;
        state_nxt    = S_FIN;
        if (op_ld || op_rti) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_WB;
        end else if (op_ind) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_MEM1;
        end else if (op_st) begin
          cmd.mem_wr = 1'b1;
        end
      end
      S_MEM1: begin
        // pointer word now in read data
        cmd.addr_sel = lc3x_pkg::MA_RDAT;
        if (sts.opcode == lc3x_pkg::OP_STI) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_WB;
        end
      end
      S_WB: begin
        if (op_rti) cmd.rti_fin = 1'b1;
        else        cmd.wb_mem  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: if (!out_valid_r || out_ready) begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid)
    else $error("finish without result");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> state_r == S_DEC)
    else $error("accepted item not decoded");
`endif

endmodule

// ===== sv/lc3_instruction_executor.sv =====
// lc3_instruction_executor: top level joining sequencer and datapath
// depends on lc3x_pkg, lc3x_if, lc3x_ctrl, lc3x_datapath
//
// channel | dir | payload
// in      | in  | req_type, instruction, mem_address, write_data, reg_index
// out     | out | status, read_data, next_pc, cond_flags, trap_vector
// cfg     | in  | cfg_we, cfg_wdata (start_address)
//
// an item passes idle, decode and fin; restart, register and memory requests and halted
// execute need no more; alu, branch, jump, trap, reserved, ST and STR add execute,
// LD/LDR/RTI execute and write-back, STI execute and pointer read, LDI all three of these.
// synchronous active-low reset; memory is not cleared.
// a stalled result holds the block in its final step until taken.
module lc3_instruction_executor (
  input  logic       clk,
  input  logic       rst_n,
  lc3x_req_if.sink   in_ch,
  lc3x_rsp_if.source out_ch,
  input  logic       cfg_we,
  input  logic [15:0] cfg_wdata
);

  lc3x_pkg::lc3x_cmd_t cmd;
  lc3x_pkg::lc3x_sts_t sts;

  lc3x_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  lc3x_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_instruction  (in_ch.instruction),
    .in_mem_address  (in_ch.mem_address),
    .in_write_data   (in_ch.write_data),
    .in_reg_index    (in_ch.reg_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .res_status      (out_ch.status),
    .res_read_data   (out_ch.read_data),
    .res_next_pc     (out_ch.next_pc),
    .res_cond_flags  (out_ch.cond_flags),
    .res_trap_vector (out_ch.trap_vector)
  );

endmodule

// ===== verif/lc3_instruction_executor_tb.sv =====
// lc3_instruction_executor_tb: self-checking bench that runs directed and random items
// through the executor and checks each result against its own model of the machine state
// depends on lc3x_pkg, lc3x_if and the lc3_instruction_executor top level
module lc3_instruction_executor_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 120;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] instruction;
    logic [15:0] mem_address;
    logic [15:0] write_data;
    logic [3:0]  reg_index;
  } lc3_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_data;
    logic [15:0] next_pc;
    logic [2:0]  cond_flags;
    logic [7:0]  trap_vector;
  } lc3_rsp_t;

  typedef struct packed {
    lc3_req_t req;
    logic     typed;
    lc3_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  lc3x_req_if in_if();
  lc3x_rsp_if out_if();

  lc3_instruction_executor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // machine state as the block should hold it
  logic [15:0] arch_gpr [8];
  logic [15:0] arch_pc;
  logic [2:0]  arch_flags;
  bit          arch_halted;
  logic [15:0] arch_mem [0:65535];
  bit          mem_written [0:65535];
  logic [15:0] written_addrs [$];
  logic [15:0] arch_start;

  lc3_rsp_t result_q [$];
  int mismatches = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] sx(input logic [15:0] v, input int n);
    logic signed [15:0] t;
    t = v << (16 - n);
    return t >>> (16 - n);
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return 3'b010;
    else if (v[15]) return 3'b100;
    else return 3'b001;
  endfunction

  // advance the machine state by one item and return what the block must report
  task automatic predict_item(input lc3_req_t r, output lc3_rsp_t e);
    logic [15:0] ins, p, a;
    logic [2:0]  dr, sr;
    ins = r.instruction;
    dr = ins[11:9];
    sr = ins[8:6];
    e = '0;
    case (r.req_type)
      lc3x_pkg::REQ_EXEC: begin
        if (arch_halted) begin
          e.status = lc3x_pkg::ST_IGNORED;
        end else begin
          arch_pc = arch_pc + 16'd1;
          p = arch_pc;
          case (ins[15:12])
            lc3x_pkg::OP_BR:
              if ((ins[11:9] & arch_flags) != 3'b000) arch_pc = p + sx(ins, 9);
            lc3x_pkg::OP_ADD: begin
              a = arch_gpr[sr] + (ins[5] ? sx(ins, 5) : arch_gpr[ins[2:0]]);
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_LD: begin
              a = arch_mem[p + sx(ins, 9)];
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_ST: begin
              a = p + sx(ins, 9);
              arch_mem[a] = arch_gpr[dr]; mem_written[a] = 1'b1;
            end
            lc3x_pkg::OP_JSR: begin
              a = ins[11] ? p + sx(ins, 11) : arch_gpr[sr];
              arch_gpr[7] = p; arch_pc = a;
            end
            lc3x_pkg::OP_AND: begin
              a = arch_gpr[sr] & (ins[5] ? sx(ins, 5) : arch_gpr[ins[2:0]]);
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_LDR: begin
              a = arch_mem[arch_gpr[sr] + sx(ins, 6)];
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_STR: begin
              a = arch_gpr[sr] + sx(ins, 6);
              arch_mem[a] = arch_gpr[dr]; mem_written[a] = 1'b1;
            end
            lc3x_pkg::OP_RTI: begin
              a = arch_gpr[6];
              arch_pc = arch_mem[a]; arch_gpr[6] = a + 16'd1;
            end
            lc3x_pkg::OP_NOT: begin
              a = ~arch_gpr[sr];
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_LDI: begin
              a = arch_mem[arch_mem[p + sx(ins, 9)]];
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            lc3x_pkg::OP_STI: begin
              a = arch_mem[p + sx(ins, 9)];
              arch_mem[a] = arch_gpr[dr]; mem_written[a] = 1'b1;
            end
            lc3x_pkg::OP_JMP: arch_pc = arch_gpr[sr];
            lc3x_pkg::OP_RES: begin
              arch_halted = 1'b1; e.status = lc3x_pkg::ST_RESERVED;
            end
            lc3x_pkg::OP_LEA: begin
              a = p + sx(ins, 9);
              arch_gpr[dr] = a; arch_flags = flags_of(a);
            end
            default: begin
              arch_gpr[7] = p; e.status = lc3x_pkg::ST_TRAP; e.trap_vector = ins[7:0];
            end
          endcase
        end
      end
      lc3x_pkg::REQ_MEM_WR: begin
        arch_mem[r.mem_address] = r.write_data;
        mem_written[r.mem_address] = 1'b1;
      end
      lc3x_pkg::REQ_MEM_RD: e.read_data = arch_mem[r.mem_address];
      lc3x_pkg::REQ_REG_RD: begin
        if (r.reg_index < 4'd8) e.read_data = arch_gpr[r.reg_index[2:0]];
        else if (r.reg_index == lc3x_pkg::RIDX_PC) e.read_data = arch_pc;
        else if (r.reg_index == lc3x_pkg::RIDX_FLAGS) e.read_data = {13'd0, arch_flags};
      end
      lc3x_pkg::REQ_RESTART: begin
        arch_pc = arch_start; arch_halted = 1'b0;
      end
      default: ;
    endcase
    e.next_pc = arch_pc;
    e.cond_flags = arch_flags;
  endtask

  // present one item and hold it until taken; called at a rising edge
  task automatic drive_item(input lc3_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= r.req_type;
    in_if.instruction <= r.instruction;
    in_if.mem_address <= r.mem_address;
    in_if.write_data <= r.write_data;
    in_if.reg_index <= r.reg_index;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_item(input lc3_req_t r, input bit typed, input lc3_rsp_t typed_rsp);
    lc3_rsp_t e;
    predict_item(r, e);
    result_q.push_back(typed ? typed_rsp : e);
    drive_item(r);
  endtask

  // make sure a word has a value before anything reads it
  task automatic fill_word(input logic [15:0] addr);
    lc3_req_t w;
    if (!mem_written[addr]) begin
      w = '0;
      w.req_type = lc3x_pkg::REQ_MEM_WR;
      w.mem_address = addr;
      w.write_data = (written_addrs.size() > 0 && $urandom_range(3) == 0) ?
                     written_addrs[$urandom_range(written_addrs.size() - 1)] :
                     16'($urandom);
      w.instruction = 16'($urandom);
      w.reg_index = 4'($urandom);
      written_addrs.push_back(addr);
      send_item(w, 1'b0, '0);
    end
  endtask

  // issue an item after writing every word its reads touch
  task automatic issue(input lc3_req_t r, input bit typed, input lc3_rsp_t typed_rsp);
    logic [15:0] p1, ins, ptr;
    ins = r.instruction;
    p1 = arch_pc + 16'd1;
    if (r.req_type == lc3x_pkg::REQ_MEM_RD) fill_word(r.mem_address);
    if (r.req_type == lc3x_pkg::REQ_EXEC && !arch_halted) begin
      case (ins[15:12])
        lc3x_pkg::OP_LD: fill_word(p1 + sx(ins, 9));
        lc3x_pkg::OP_LDR: fill_word(arch_gpr[ins[8:6]] + sx(ins, 6));
        lc3x_pkg::OP_RTI: fill_word(arch_gpr[6]);
        lc3x_pkg::OP_STI: fill_word(p1 + sx(ins, 9));
        lc3x_pkg::OP_LDI: begin
          ptr = p1 + sx(ins, 9);
          fill_word(ptr);
          fill_word(arch_mem[ptr]);
        end
        default: ;
      endcase
    end
    send_item(r, typed, typed_rsp);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start(input logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    arch_start = v;
  endtask

  function automatic dir_row_t row(input logic [2:0] rt, input logic [15:0] ins,
                                   input logic [15:0] addr, input logic [15:0] data,
                                   input logic [3:0] ri, input bit typed,
                                   input logic [1:0] st, input logic [15:0] rd,
                                   input logic [15:0] pc, input logic [2:0] fl,
                                   input logic [7:0] vec);
    dir_row_t d;
    d.req = '{rt, ins, addr, data, ri};
    d.typed = typed;
    d.rsp = '{st, rd, pc, fl, vec};
    return d;
  endfunction

  // result channel back-pressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    lc3_rsp_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.status, out_if.read_data, out_if.next_pc, out_if.cond_flags,
              out_if.trap_vector};
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    dir_row_t dir_tab [$];
    lc3_req_t r;
    int idle_s [4] = '{0, 85, 0, 31};
    int stall_r [4] = '{0, 0, 85, 31};
    logic [15:0] start_vals [4] = '{16'h0000, 16'hFFFF, 16'h3000, 16'h0000};
    int k;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.req_type <= '0;
    in_if.instruction <= '0;
    in_if.mem_address <= '0;
    in_if.write_data <= '0;
    in_if.reg_index <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    start_vals[3] = 16'($urandom);
    for (int i = 0; i < 8; i++) arch_gpr[i] = '0;
    arch_pc = lc3x_pkg::START_RESET;
    arch_flags = lc3x_pkg::FLAGS_RESET;
    arch_halted = 1'b0;
    arch_start = lc3x_pkg::START_RESET;
    for (int i = 0; i < 65536; i++) mem_written[i] = 1'b0;

    // directed rows: state after reset, extremes, status codes, then every opcode
    dir_tab.push_back(row(lc3x_pkg::REQ_REG_RD, 0, 0, 0, lc3x_pkg::RIDX_PC, 1,
                          lc3x_pkg::ST_OK, 16'h3000, 16'h3000, 2, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_REG_RD, 0, 0, 0, lc3x_pkg::RIDX_FLAGS, 1,
                          lc3x_pkg::ST_OK, 2, 16'h3000, 2, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_REG_RD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3000, 2, 0));
    dir_tab.push_back(row(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3000, 2, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_MEM_WR, 0, 16'hFFFF, 16'hFFFF, 0, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3000, 2, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_MEM_RD, 0, 16'hFFFF, 0, 0, 1,
                          lc3x_pkg::ST_OK, 16'hFFFF, 16'h3000, 2, 0));
    // add immediate minus sixteen into r0
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h1030, 0, 0, 0, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3001, 4, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hF0FF, 0, 0, 0, 1,
                          lc3x_pkg::ST_TRAP, 0, 16'h3002, 4, 8'hFF));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hDFFF, 0, 0, 0, 1,
                          lc3x_pkg::ST_RESERVED, 0, 16'h3003, 4, 0));
    // halted: execute ignored, memory still works
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h1FFF, 0, 0, 0, 1,
                          lc3x_pkg::ST_IGNORED, 0, 16'h3003, 4, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_MEM_WR, 0, 16'h1234, 16'h5678, 0, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3003, 4, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_RESTART, 0, 0, 0, 0, 1,
                          lc3x_pkg::ST_OK, 0, 16'h3000, 4, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h9E3F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h5007, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h563F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h1201, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h0FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hE1FF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h2400, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h6C3F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hA1FF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h3E00, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hB000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h4FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // jsrr through r7 reads the base before the link write
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h41C0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'hC1C0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_EXEC, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(lc3x_pkg::REQ_MEM_RD, 0, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    // random phases, each under its own start address and mix of sender idle and receiver stall
    for (int ph = 0; ph < 4; ph++) begin
      write_start(start_vals[ph]);
      send_idle_pct = idle_s[ph];
      recv_stall_pct = stall_r[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r.instruction = 16'($urandom);
        r.mem_address = 16'($urandom);
        r.write_data = 16'($urandom);
        r.reg_index = 4'($urandom);
        k = $urandom_range(99);
        if (arch_halted && $urandom_range(1)) r.req_type = lc3x_pkg::REQ_RESTART;
        else if (k < 8) r.req_type = lc3x_pkg::REQ_MEM_WR;
        else if (k < 14) begin
          r.req_type = lc3x_pkg::REQ_MEM_RD;
          if (written_addrs.size() > 0 && $urandom_range(1))
            r.mem_address = written_addrs[$urandom_range(written_addrs.size() - 1)];
        end
        else if (k < 24) r.req_type = lc3x_pkg::REQ_REG_RD;
        else if (k < 27) r.req_type = lc3x_pkg::REQ_RESTART;
        else if (k < 30) r.req_type = 3'($urandom_range(7, 5));
        else r.req_type = lc3x_pkg::REQ_EXEC;
        if (r.req_type == lc3x_pkg::REQ_MEM_WR) written_addrs.push_back(r.mem_address);
        issue(r, 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lc3x_pkg.sv
sv/lc3x_if.sv
sv/lc3x_datapath.sv
sv/lc3x_ctrl.sv
sv/lc3_instruction_executor.sv
verif/lc3_instruction_executor_tb.sv
